/* rtl/core/box_filter_3x3_rgb_core_defines.svh */
// assertion macros used by the box filter rtl
`ifndef BOX_FILTER_3X3_RGB_CORE_DEFINES_SVH
`define BOX_FILTER_3X3_RGB_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define BF3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BF3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BF3_ASSERT(label, prop, msg)
`define BF3_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

/* rtl/core/bf3_pkg.sv */
// types, constants and helpers of the 3x3 box filter
package bf3_pkg;

  localparam int MAX_ROW_LEN = 1024;
  localparam int ADDR_W      = $clog2(MAX_ROW_LEN);
  localparam int WID_W       = $clog2(MAX_ROW_LEN + 1);
  localparam int PEND_W      = $clog2(MAX_ROW_LEN + 2);

  localparam int PIX_W       = 8;
  localparam int LEN_W       = 11;
  localparam int CNT_W       = 16;
  localparam int COL_SUM_W   = PIX_W + 2;
  localparam int BOX_SUM_W   = PIX_W + 4;

  // floor(s / 9) as (s * ceil(2^16 / 9)) >> 16, exact for any nine-pixel sum
  localparam int DIV_SHIFT   = 16;
  localparam int RECIP_W     = 13;
  localparam int RECIP9      = (2 ** DIV_SHIFT + 8) / 9;

  localparam int OUT_DEPTH   = 8;
  localparam int FIFO_PTR_W  = $clog2(OUT_DEPTH);
  localparam int CRED_W      = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0] ROW_LENGTH_RESET = LEN_W'(1024);
  localparam logic [CNT_W-1:0] ROW_COUNT_RESET  = CNT_W'(1024);

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
    rgb_t lower;
  } column_t;

  typedef struct packed {
    rgb_t upper;
    rgb_t middle;
  } line_t;

  typedef struct packed {
    logic [COL_SUM_W-1:0] blue;
    logic [COL_SUM_W-1:0] green;
    logic [COL_SUM_W-1:0] red;
  } col_sum_t;

  typedef struct packed {
    logic [BOX_SUM_W-1:0] blue;
    logic [BOX_SUM_W-1:0] green;
    logic [BOX_SUM_W-1:0] red;
  } box_sum_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } lb_ctrl_t;

  typedef struct packed {
    rgb_t px;
    logic frame_end;
  } result_t;

  function automatic logic [PIX_W-1:0] div9(input logic [BOX_SUM_W-1:0] s);
    logic [BOX_SUM_W+RECIP_W-1:0] p;
    p = (BOX_SUM_W + RECIP_W)'(s) * (BOX_SUM_W + RECIP_W)'(RECIP9);
    return p[DIV_SHIFT +: PIX_W];
  endfunction

endpackage

/* rtl/core/bf3_stream_if.sv */
// pixel, result and register-write channel interfaces
interface bf3_pixel_in_if import bf3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_red;
  logic [PIX_W-1:0] pixel_green;
  logic [PIX_W-1:0] pixel_blue;
  logic             fill_only;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, fill_only,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, fill_only,
    output ready
  );
endinterface

interface bf3_pixel_out_if import bf3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] out_red;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_blue;
  logic             frame_end;

  modport source (
    output valid, out_red, out_green, out_blue, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, frame_end,
    output ready
  );
endinterface

interface bf3_cfg_if import bf3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/bf3_line_buf.sv */
// two-row line memory, one read and one write per cycle, write-first on a hit
module bf3_line_buf import bf3_pkg::*; (
  input  logic     clk,
  input  lb_ctrl_t ctrl,
  input  line_t    wr_line,
  output line_t    rd_line
);

  line_t mem [MAX_ROW_LEN];
  line_t rd_q;
  line_t fwd_q;
  logic  fwd_hit;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[ctrl.wr_addr] <= wr_line;
    end
  end

  // a read of the column being written this cycle takes the new data
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_q    <= mem[ctrl.rd_addr];
      fwd_hit <= ctrl.wr_en && (ctrl.wr_addr == ctrl.rd_addr);
      fwd_q   <= wr_line;
    end
  end

  assign rd_line = fwd_hit ? fwd_q : rd_q;

endmodule

/* rtl/core/bf3_cell.sv */
// one window column: holds three pixels, shifts to its neighbor, sums per channel
module bf3_cell import bf3_pkg::*; (
  input  logic     clk,
  input  logic     shift,
  input  column_t  col_in,
  output column_t  col_out,
  output col_sum_t sums
);

  column_t col_q;

  always_ff @(posedge clk) begin
    if (shift) begin
      col_q <= col_in;
    end
  end

  assign col_out = col_q;

  always_comb begin
    sums.red   = COL_SUM_W'(col_q.upper.red) + COL_SUM_W'(col_q.middle.red)
               + COL_SUM_W'(col_q.lower.red);
    sums.green = COL_SUM_W'(col_q.upper.green) + COL_SUM_W'(col_q.middle.green)
               + COL_SUM_W'(col_q.lower.green);
    sums.blue  = COL_SUM_W'(col_q.upper.blue) + COL_SUM_W'(col_q.middle.blue)
               + COL_SUM_W'(col_q.lower.blue);
  end

endmodule

/* rtl/core/bf3_out_fifo.sv */
// result queue in front of the output channel
module bf3_out_fifo import bf3_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  bf3_pixel_out_if.source smoothed
);

  result_t               slots [OUT_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [CRED_W-1:0]     count;
  logic                  pop;

  assign pop = smoothed.valid && smoothed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CRED_W'(1);
        2'b01:   count <= count - CRED_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign smoothed.valid     = (count != '0);
  assign smoothed.out_red   = slots[rd_ptr].px.red;
  assign smoothed.out_green = slots[rd_ptr].px.green;
  assign smoothed.out_blue  = slots[rd_ptr].px.blue;
  assign smoothed.frame_end = slots[rd_ptr].frame_end;

endmodule

/* rtl/core/box_filter_3x3_rgb_core.sv */
// 3x3 box filter over RGB frames in raster order: each request carries one pixel
// (or a fill request that drains the frame's tail) and the block takes one request
// per clock while ready is high, with no gaps between frames. The result for raster
// pixel k is caused by the request carrying pixel k + row_length + 1; border pixels
// pass unchanged, inner pixels get floor(sum of nine / 9) per channel. After the last
// pixel of a frame, row_length + 1 fill requests (row_length when the frame has
// one row) bring out the remaining results, the last one flagged by frame_end.
// A result leaves the four-stage datapath (line memory read, window shift, nine-term
// sum, reciprocal multiply) and waits in an eight-entry queue; ready drops only while
// eight results are outstanding. The line memory needs no clearing pass after reset.
// Write row_length and row_count only while the block is idle; each such write
// restarts the frame.
`include "box_filter_3x3_rgb_core_defines.svh"
module box_filter_3x3_rgb_core import bf3_pkg::*; (
  input  logic clk,
  input  logic rst,
  bf3_pixel_in_if.sink    pixels,
  bf3_pixel_out_if.source smoothed,
  bf3_cfg_if.sink         regs
);

  // registers and frame position
  logic [LEN_W-1:0]  row_length;
  logic [CNT_W-1:0]  row_count;
  logic [ADDR_W-1:0] col;
  logic [CNT_W-1:0]  row;
  logic [PEND_W-1:0] pending;
  logic              fill_upper;
  logic [ADDR_W-1:0] fill_col;
  logic [CRED_W-1:0] inflight;

  logic [WID_W-1:0]  w_eff;
  logic [CNT_W-1:0]  h_eff;
  logic [ADDR_W-1:0] w_last;
  logic [ADDR_W-1:0] cur_col;
  logic [CNT_W-1:0]  cur_row;
  logic              col_last;
  logic              row_last;
  logic              pix_emit;
  logic              pix_inner;
  logic              fill_go;
  logic              accept;
  logic              accept_pix;
  logic              accept_fill;
  logic              take_emit;
  logic              cfg_hit;
  logic              out_take;

  // pipeline
  logic              s1_pix;
  logic              s1_emit;
  logic              s1_fill;
  logic              s1_inner;
  logic              s1_upper_sel;
  logic              s1_last;
  logic [ADDR_W-1:0] s1_addr;
  rgb_t              s1_pixel;

  logic              s2_emit;
  logic              s2_fill;
  logic              s2_inner;
  logic              s2_last;
  rgb_t              s2_fill_px;

  logic              s3_emit;
  logic              s3_inner;
  logic              s3_last;
  rgb_t              s3_px;
  box_sum_t          s3_sum;

  logic              s4_emit;
  logic              s4_inner;
  logic              s4_last;
  rgb_t              s4_px;
  rgb_t              s4_avg;

  lb_ctrl_t          lb_ctrl;
  line_t             wr_line;
  line_t             rd_line;
  column_t           new_col;
  column_t           col2;
  column_t           col1;
  col_sum_t          sums0;
  col_sum_t          sums1;
  col_sum_t          sums2;
  box_sum_t          box_sum;
  result_t           push_data;

  always_comb begin
    priority if (row_length == '0) begin
      w_eff = WID_W'(1);
    end else if (int'(row_length) > MAX_ROW_LEN) begin
      w_eff = WID_W'(MAX_ROW_LEN);
    end else begin
      w_eff = WID_W'(row_length);
    end
  end

  assign h_eff   = (row_count == '0) ? CNT_W'(1) : row_count;
  assign w_last  = ADDR_W'(w_eff - WID_W'(1));
  assign cur_col = (WID_W'(col) >= w_eff) ? '0 : col;
  assign cur_row = (row >= h_eff) ? '0 : row;

  assign col_last  = (WID_W'(cur_col) + WID_W'(1)) >= w_eff;
  assign row_last  = (cur_row + CNT_W'(1)) >= h_eff;
  // results start once a full row plus one pixel has gone by
  assign pix_emit  = (cur_row >= CNT_W'(2)) || ((cur_row == CNT_W'(1)) && (cur_col != '0));
  assign pix_inner = (cur_row >= CNT_W'(2)) && (cur_col >= ADDR_W'(2));
  assign fill_go   = (pending != '0);

  assign accept      = pixels.valid && pixels.ready;
  assign accept_pix  = accept && !pixels.fill_only;
  assign accept_fill = accept && pixels.fill_only && fill_go;
  assign take_emit   = (accept_pix && pix_emit) || accept_fill;

  assign cfg_hit  = regs.valid && regs.ready
                 && ((regs.index == REG_ROW_LENGTH) || (regs.index == REG_ROW_COUNT));
  assign out_take = smoothed.valid && smoothed.ready;

  assign regs.ready   = 1'b1;
  assign pixels.ready = (inflight < CRED_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= ROW_LENGTH_RESET;
      row_count  <= ROW_COUNT_RESET;
      col        <= '0;
      row        <= '0;
      pending    <= '0;
      fill_upper <= 1'b0;
      fill_col   <= '0;
    end else if (cfg_hit) begin
      if (regs.index == REG_ROW_LENGTH) begin
        row_length <= regs.data[LEN_W-1:0];
      end else begin
        row_count <= regs.data[CNT_W-1:0];
      end
      col        <= '0;
      row        <= '0;
      pending    <= '0;
      fill_upper <= 1'b0;
      fill_col   <= '0;
    end else if (accept_pix) begin
      pending    <= '0;
      fill_upper <= 1'b0;
      fill_col   <= '0;
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row <= '0;
          // tail: last column of the row above, then the whole last row
          if (h_eff >= CNT_W'(2)) begin
            pending    <= PEND_W'(w_eff) + PEND_W'(1);
            fill_upper <= 1'b1;
          end else begin
            pending <= PEND_W'(w_eff);
          end
        end else begin
          row <= cur_row + CNT_W'(1);
        end
      end else begin
        col <= cur_col + ADDR_W'(1);
        row <= cur_row;
      end
    end else if (accept_fill) begin
      pending <= pending - PEND_W'(1);
      if (fill_upper) begin
        fill_upper <= 1'b0;
      end else begin
        fill_col <= fill_col + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      unique case ({take_emit, out_take})
        2'b10:   inflight <= inflight + CRED_W'(1);
        2'b01:   inflight <= inflight - CRED_W'(1);
        default: inflight <= inflight;
      endcase
    end
  end

  // stage 1: line memory read data arrives, memory write and window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_pix  <= 1'b0;
      s1_emit <= 1'b0;
      s1_fill <= 1'b0;
    end else begin
      s1_pix  <= accept_pix;
      s1_emit <= take_emit;
      s1_fill <= accept_fill;
    end
  end

  always_ff @(posedge clk) begin
    s1_inner     <= accept_pix && pix_inner;
    s1_upper_sel <= fill_upper;
    s1_last      <= accept_fill && (pending == PEND_W'(1));
    s1_addr      <= cur_col;
    s1_pixel     <= '{blue: pixels.pixel_blue, green: pixels.pixel_green,
                      red: pixels.pixel_red};
  end

  always_comb begin
    lb_ctrl.rd_en   = accept_pix || accept_fill;
    lb_ctrl.rd_addr = accept_pix ? cur_col : (fill_upper ? w_last : fill_col);
    lb_ctrl.wr_en   = s1_pix;
    lb_ctrl.wr_addr = s1_addr;
  end

  assign wr_line = '{upper: rd_line.middle, middle: s1_pixel};
  assign new_col = '{upper: rd_line.upper, middle: rd_line.middle, lower: s1_pixel};

  bf3_line_buf u_line_buf (
    .clk     (clk),
    .ctrl    (lb_ctrl),
    .wr_line (wr_line),
    .rd_line (rd_line)
  );

  bf3_cell u_cell2 (
    .clk     (clk),
    .shift   (s1_pix),
    .col_in  (new_col),
    .col_out (col2),
    .sums    (sums2)
  );

  bf3_cell u_cell1 (
    .clk     (clk),
    .shift   (s1_pix),
    .col_in  (col2),
    .col_out (col1),
    .sums    (sums1)
  );

  bf3_cell u_cell0 (
    .clk     (clk),
    .shift   (s1_pix),
    .col_in  (col1),
    .col_out (),
    .sums    (sums0)
  );

  // stage 2: window holds this pixel's neighborhood
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_emit <= 1'b0;
    end else begin
      s2_emit <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    s2_fill    <= s1_fill;
    s2_inner   <= s1_inner;
    s2_last    <= s1_last;
    s2_fill_px <= s1_upper_sel ? rd_line.upper : rd_line.middle;
  end

  always_comb begin
    box_sum.red   = BOX_SUM_W'(sums0.red) + BOX_SUM_W'(sums1.red) + BOX_SUM_W'(sums2.red);
    box_sum.green = BOX_SUM_W'(sums0.green) + BOX_SUM_W'(sums1.green)
                  + BOX_SUM_W'(sums2.green);
    box_sum.blue  = BOX_SUM_W'(sums0.blue) + BOX_SUM_W'(sums1.blue)
                  + BOX_SUM_W'(sums2.blue);
  end

  // stage 3: sums registered
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_emit <= 1'b0;
    end else begin
      s3_emit <= s2_emit;
    end
  end

  always_ff @(posedge clk) begin
    s3_inner <= s2_inner;
    s3_last  <= s2_last;
    s3_px    <= s2_fill ? s2_fill_px : col1.middle;
    s3_sum   <= box_sum;
  end

  // stage 4: divide by nine through the reciprocal
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_emit <= 1'b0;
    end else begin
      s4_emit <= s3_emit;
    end
  end

  always_ff @(posedge clk) begin
    s4_inner     <= s3_inner;
    s4_last      <= s3_last;
    s4_px        <= s3_px;
    s4_avg.red   <= div9(s3_sum.red);
    s4_avg.green <= div9(s3_sum.green);
    s4_avg.blue  <= div9(s3_sum.blue);
  end

  assign push_data = '{px: (s4_inner ? s4_avg : s4_px), frame_end: s4_last};

  bf3_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s4_emit),
    .push_data (push_data),
    .smoothed  (smoothed)
  );

  `BF3_ASSERT(a_credit_bound, inflight <= CRED_W'(OUT_DEPTH), "outstanding results exceed queue")
  `BF3_ASSERT(a_pending_bound, pending <= PEND_W'(w_eff) + PEND_W'(1), "tail count too large")
  `BF3_ASSERT(a_upper_first, fill_upper |-> pending == PEND_W'(w_eff) + PEND_W'(1), "tail upper flag out of step")
  `BF3_ASSERT(a_fill_col_track, (fill_go && !fill_upper) |-> (PEND_W'(fill_col) + pending == PEND_W'(w_eff)), "tail column out of step")

endmodule
